// ----- sv/spgc_pkg.sv -----
// shared types and constants for the soft potentiometer gesture classifier
`timescale 1ns / 1ps

package spgc_pkg;

    // fixed field widths
    localparam int THR_BITS       = 10;
    localparam int HOLD_BITS      = 16;
    localparam int TIME_BITS      = 32;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LOW_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MOVE_REGION   = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HOLD_TIME_MS  = 2'd2;

    // configuration reset values
    localparam logic [THR_BITS-1:0]  LOW_THRESHOLD_RST = 10'd5;
    localparam logic [THR_BITS-1:0]  MOVE_REGION_RST   = 10'd150;
    localparam logic [HOLD_BITS-1:0] HOLD_TIME_MS_RST  = 16'd2000;

    // item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    // gesture kinds
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_SWIPE  = 2'd2,
        KIND_RUB    = 2'd3
    } kind_t;

    // configuration register set
    typedef struct packed {
        logic [THR_BITS-1:0]  low_threshold;
        logic [THR_BITS-1:0]  move_region;
        logic [HOLD_BITS-1:0] hold_time_ms;
    } cfg_t;

endpackage

// ----- sv/spgc_tracker.sv -----
// gesture state registers and the per-item update and snapshot logic
`timescale 1ns / 1ps

module spgc_tracker #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spgc_pkg::cfg_t                 cfg,
    input  logic                           step,
    input  logic                           op,
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  logic [spgc_pkg::TIME_BITS-1:0] now_ms,
    output logic                           res_ready,
    output spgc_pkg::kind_t                res_kind,
    output logic [SAMPLE_BITS-1:0]         res_start,
    output logic [SAMPLE_BITS-1:0]         res_last,
    output logic [spgc_pkg::TIME_BITS-1:0] res_elapsed,
    output logic                           res_held
);
    import spgc_pkg::*;

    // compare width wide enough for samples and thresholds
    localparam int CW = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    kind_t                  kind_reg,  kind_next;
    logic [SAMPLE_BITS-1:0] begin_reg, begin_next;
    logic [SAMPLE_BITS-1:0] end_reg,   end_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic                   hold_reg,  hold_next;
    logic                   done_reg,  done_next;

    logic [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS-1:0] span;
    logic [CW-1:0]          v_ext;
    logic [CW-1:0]          thr_ext;
    logic                   above_thr;
    logic                   below_thr;
    logic                   far_away;
    logic                   same_dir;
    logic [TIME_BITS-1:0]   age;
    logic [TIME_BITS-1:0]   elapsed;

    // distance from start and threshold compares
    assign diff      = {1'b0, sample} - {1'b0, begin_reg};
    assign span      = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
    assign v_ext     = CW'(sample);
    assign thr_ext   = CW'(cfg.low_threshold);
    assign above_thr = v_ext > thr_ext;
    assign below_thr = v_ext < thr_ext;
    assign far_away  = CW'(span) > CW'(cfg.move_region);

    // reversal: new sample lies on the start side of the last movement
    assign same_dir = ((sample < end_reg) == (begin_reg < end_reg)) &&
                      ((sample > end_reg) == (begin_reg > end_reg));

    assign elapsed = now_ms - start_reg;

    // next state and result
    always_comb
    begin
        kind_next   = kind_reg;
        begin_next  = begin_reg;
        end_next    = end_reg;
        start_next  = start_reg;
        hold_next   = hold_reg;
        done_next   = done_reg;
        age         = '0;
        res_ready   = 1'b0;
        res_kind    = kind_reg;
        res_start   = begin_reg;
        res_last    = end_reg;
        res_elapsed = '0;
        res_held    = hold_reg;
        if (op == OP_SAMPLE)
        begin
            priority if ((done_reg || kind_reg == KIND_NONE) && above_thr)
            begin
                done_next  = 1'b0;
                begin_next = sample;
                end_next   = sample;
                kind_next  = KIND_BUTTON;
                start_next = now_ms;
                hold_next  = 1'b0;
            end
            else if (kind_reg != KIND_NONE && far_away && above_thr)
            begin
                if (kind_reg == KIND_BUTTON)
                begin
                    kind_next = KIND_SWIPE;
                end
                if (kind_next == KIND_SWIPE && !hold_reg && same_dir)
                begin
                    kind_next = KIND_RUB;
                end
                end_next = sample;
            end
            else if (kind_reg != KIND_NONE && below_thr)
            begin
                done_next = 1'b1;
            end
            else
            begin
                done_next = done_reg;
            end
            // hold check on the updated gesture
            age = now_ms - start_next;
            if (kind_next != KIND_NONE && !hold_next &&
                age > TIME_BITS'(cfg.hold_time_ms))
            begin
                hold_next = 1'b1;
                if (kind_next == KIND_RUB)
                begin
                    kind_next = KIND_SWIPE;
                end
            end
            res_ready = done_next || hold_next;
            res_kind  = kind_next;
            res_start = begin_next;
            res_last  = end_next;
            res_held  = hold_next;
        end
        else
        begin
            // snapshot before clearing a finished gesture
            res_elapsed = elapsed;
            if (done_reg)
            begin
                kind_next  = KIND_NONE;
                begin_next = '0;
                end_next   = '0;
                start_next = '0;
                hold_next  = 1'b0;
            end
            done_next = 1'b0;
        end
    end

    // gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_NONE;
            begin_reg <= '0;
            end_reg   <= '0;
            start_reg <= '0;
            hold_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (step)
        begin
            kind_reg  <= kind_next;
            begin_reg <= begin_next;
            end_reg   <= end_next;
            start_reg <= start_next;
            hold_reg  <= hold_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ----- sv/soft_pot_gesture_classifier_core.sv -----
// top level: configuration registers, input and result registers, gesture tracker
//
// channel   direction  transfer when          content
// s_*       in         s_tvalid & s_tready    one sample or fetch item
// m_*       out        m_tvalid & m_tready    one result per item
// cfg_*     in         cfg_we                 register write, no read-back
//
// one item per cycle sustained while results are taken; each result passes through the input
// register, then the tracker logic, into the result register
// the gesture state update is a single compare-and-select pass in the tracker
// reset clears configuration to defaults, the gesture state and both valid flags
// a stalled result holds the pipeline; s_tready stays high while a slot is free
`timescale 1ns / 1ps

module soft_pot_gesture_classifier_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [spgc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [spgc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: sample, now_ms, zero fill
    input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0] s_tdata,
    // s_tuser: op
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: ready_res, kind, start_value, last_value, elapsed_ms, held, zero fill
    output logic [((2*SAMPLE_BITS+36+7)/8)*8-1:0] m_tdata
);
    import spgc_pkg::*;

    localparam int OUT_BITS = 2 * SAMPLE_BITS + 36;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TIME_BITS-1:0]   in_now_reg;
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    out_data_reg;

    logic                   out_free;
    logic                   step;
    logic                   res_ready;
    kind_t                  res_kind;
    logic [SAMPLE_BITS-1:0] res_start;
    logic [SAMPLE_BITS-1:0] res_last;
    logic [TIME_BITS-1:0]   res_elapsed;
    logic                   res_held;

    // pipeline flow control
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold <= LOW_THRESHOLD_RST;
            cfg_reg.move_region   <= MOVE_REGION_RST;
            cfg_reg.hold_time_ms  <= HOLD_TIME_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_LOW_THRESHOLD: cfg_reg.low_threshold <= cfg_wdata[THR_BITS-1:0];
                CFG_MOVE_REGION:   cfg_reg.move_region   <= cfg_wdata[THR_BITS-1:0];
                CFG_HOLD_TIME_MS:  cfg_reg.hold_time_ms  <= cfg_wdata[HOLD_BITS-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg     <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_now_reg    <= s_tdata[SAMPLE_BITS +: TIME_BITS];
        end
        if (step)
        begin
            out_data_reg <= {res_held, res_elapsed, res_last, res_start, res_kind, res_ready};
        end
    end

    // gesture state and update
    spgc_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .step        (step),
        .op          (in_op_reg),
        .sample      (in_sample_reg),
        .now_ms      (in_now_reg),
        .res_ready   (res_ready),
        .res_kind    (res_kind),
        .res_start   (res_start),
        .res_last    (res_last),
        .res_elapsed (res_elapsed),
        .res_held    (res_held)
    );

endmodule

// ----- tb/sv/tb_soft_pot_gesture_classifier_core.sv -----
// self-checking testbench for the soft potentiometer gesture classifier core
`timescale 1ns / 1ps

module tb_soft_pot_gesture_classifier_core;

    import spgc_pkg::*;

    localparam int SAMPLE_W    = 10;
    localparam int SDATA_W     = ((SAMPLE_W + 32 + 7) / 8) * 8;
    localparam int MDATA_W     = ((2 * SAMPLE_W + 36 + 7) / 8) * 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

    // one result as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic                held;
        logic [31:0]         elapsed_ms;
        logic [SAMPLE_W-1:0] last_value;
        logic [SAMPLE_W-1:0] start_value;
        kind_t               kind;
        logic                ready_res;
    } gesture_report_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    // s_tdata: sample, now_ms, zero fill
    logic [SDATA_W-1:0] s_tdata;
    // s_tuser: op
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    // m_tdata: ready_res, kind, start_value, last_value, elapsed_ms, held
    logic [MDATA_W-1:0] m_tdata;

    // gesture tracker shadow state and register shadows
    kind_t               trk_kind;
    logic [SAMPLE_W-1:0] trk_begin;
    logic [SAMPLE_W-1:0] trk_end;
    logic [31:0]         trk_start_ms;
    logic                trk_held;
    logic                trk_done;
    logic [SAMPLE_W-1:0] thr_low;
    logic [SAMPLE_W-1:0] thr_move;
    logic [15:0]         thr_hold;

    gesture_report_t pending_reports[$];
    int          errors = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    int          hold_off_req = 0;
    logic [31:0] ms_clock = 32'd0;

    soft_pot_gesture_classifier_core #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int sign_of_diff(int d);
        if (d < 0)
            return -1;
        if (d > 0)
            return 1;
        return 0;
    endfunction

    // advance the tracker by one item and return the report it produces
    function automatic gesture_report_t classify_item(logic op, logic [SAMPLE_W-1:0] v,
                                                      logic [31:0] now);
        gesture_report_t rep;
        int          span;
        logic [31:0] touch_ms;
        rep = '0;
        if (op == OP_SAMPLE)
        begin
            span = int'(v) - int'(trk_begin);
            if (span < 0)
                span = -span;
            if ((trk_done || trk_kind == KIND_NONE) && v > thr_low)
            begin
                // new touch
                trk_done     = 1'b0;
                trk_begin    = v;
                trk_end      = v;
                trk_kind     = KIND_BUTTON;
                trk_start_ms = now;
                trk_held     = 1'b0;
            end
            else if (trk_kind != KIND_NONE && span > int'(thr_move) && v > thr_low)
            begin
                // movement beyond the region
                if (trk_kind == KIND_BUTTON)
                    trk_kind = KIND_SWIPE;
                if (trk_kind == KIND_SWIPE && !trk_held &&
                    sign_of_diff(int'(v) - int'(trk_end)) ==
                    sign_of_diff(int'(trk_begin) - int'(trk_end)))
                    trk_kind = KIND_RUB;
                trk_end = v;
            end
            else if (trk_kind != KIND_NONE && v < thr_low)
            begin
                trk_done = 1'b1;
            end
            // hold check, also after release
            touch_ms = now - trk_start_ms;
            if (trk_kind != KIND_NONE && !trk_held && touch_ms > {16'd0, thr_hold})
            begin
                trk_held = 1'b1;
                if (trk_kind == KIND_RUB)
                    trk_kind = KIND_SWIPE;
            end
            rep.ready_res   = trk_done | trk_held;
            rep.kind        = trk_kind;
            rep.start_value = trk_begin;
            rep.last_value  = trk_end;
            rep.elapsed_ms  = 32'd0;
            rep.held        = trk_held;
        end
        else
        begin
            // snapshot first, then clear a finished gesture
            rep.ready_res   = 1'b0;
            rep.kind        = trk_kind;
            rep.start_value = trk_begin;
            rep.last_value  = trk_end;
            rep.elapsed_ms  = now - trk_start_ms;
            rep.held        = trk_held;
            if (trk_done)
            begin
                trk_kind     = KIND_NONE;
                trk_begin    = '0;
                trk_end      = '0;
                trk_start_ms = 32'd0;
                trk_held     = 1'b0;
            end
            trk_done = 1'b0;
        end
        return rep;
    endfunction

    // send one item, with bursts and random gaps between them
    task automatic send_item(logic op, logic [SAMPLE_W-1:0] v, logic [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && !no_gaps)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(SDATA_W - SAMPLE_W - 32){1'b0}}, now, v};
        // inputs are stable between edges, so ready at the falling edge decides the transfer
        do
            @(negedge clk);
        while (!s_tready);
        pending_reports.push_back(classify_item(op, v, now));
        items_sent++;
        @(posedge clk);
    endtask

    // stop sending and wait until every report has come back
    task automatic drain_reports();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all three registers back to back while idle
    task automatic set_thresholds(int lt, int mr, int ht);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_LOW_THRESHOLD;
        cfg_wdata <= CFG_DATA_BITS'(lt);
        @(posedge clk);
        thr_low   = SAMPLE_W'(lt);
        cfg_addr  <= CFG_MOVE_REGION;
        cfg_wdata <= CFG_DATA_BITS'(mr);
        @(posedge clk);
        thr_move  = SAMPLE_W'(mr);
        cfg_addr  <= CFG_HOLD_TIME_MS;
        cfg_wdata <= CFG_DATA_BITS'(ht);
        @(posedge clk);
        thr_hold  = 16'(ht);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] next_ms();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            ms_clock = ms_clock + $urandom_range(0, 400);
        else if (r < 19)
            ms_clock = ms_clock + $urandom_range(0, 70000);
        else
            ms_clock = ms_clock + $urandom;
        return ms_clock;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_touch();
        if (thr_low >= SAMPLE_MAX)
            return SAMPLE_MAX;
        return SAMPLE_W'($urandom_range(int'(thr_low) + 1, SAMPLE_MAX));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_release();
        if (thr_low == 0)
            return '0;
        return SAMPLE_W'($urandom_range(0, int'(thr_low) - 1));
    endfunction

    // a value beyond the move region, on either side of the start value, or any touch value when neither side has room
    function automatic logic [SAMPLE_W-1:0] pick_far();
        int step;
        int up;
        int down;
        step = int'(thr_move) + 1 + $urandom_range(0, 200);
        up   = int'(trk_begin) + step;
        down = int'(trk_begin) - step;
        if ($urandom_range(0, 1) == 0 && up <= SAMPLE_MAX)
            return SAMPLE_W'(up);
        if (down >= 0)
            return SAMPLE_W'(down);
        if (up <= SAMPLE_MAX)
            return SAMPLE_W'(up);
        return pick_touch();
    endfunction

    task automatic send_noise_item();
        send_item(logic'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                  $urandom);
    endtask

    // well-formed touches with random content, some noise in between
    task automatic run_gestures(int n_items);
        int first;
        int steps;
        int r;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_noise_item();
            end
            else
            begin
                send_item(OP_SAMPLE, pick_touch(), next_ms());
                steps = $urandom_range(1, 8);
                repeat (steps)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        send_item(OP_SAMPLE, pick_far(), next_ms());
                    else if (r == 5)
                        send_item(OP_SAMPLE, SAMPLE_W'(int'(trk_end) ^ $urandom_range(0, 7)),
                                  next_ms());
                    else if (r == 6)
                        send_item(OP_SAMPLE, thr_low, next_ms());
                    else if (r == 7)
                        send_item(OP_FETCH, SAMPLE_W'($urandom), next_ms());
                    else
                        send_item(OP_SAMPLE, pick_touch(), next_ms());
                end
                if ($urandom_range(0, 5) != 0)
                    send_item(OP_SAMPLE, pick_release(), next_ms());
                // late sample after release exercises the hold check on a finished touch
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_SAMPLE, pick_release(), next_ms());
                if ($urandom_range(0, 4) != 0)
                    send_item(OP_FETCH, SAMPLE_W'($urandom), next_ms());
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker: the transfer happens at the next rising edge
    initial
    begin : report_checker
        gesture_report_t got;
        gesture_report_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = gesture_report_t'(m_tdata);
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("ready_res", 32'(want.ready_res), 32'(got.ready_res));
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("start_value", 32'(want.start_value), 32'(got.start_value));
                    check_field("last_value", 32'(want.last_value), 32'(got.last_value));
                    check_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
                    check_field("held", 32'(want.held), 32'(got.held));
                end
            end
        end
    end

    // receiver: rotating stall pattern, plus a long hold-off on request
    initial
    begin : result_sink
        logic [15:0] stall_pattern;
        int          age;
        m_tready      <= 1'b0;
        stall_pattern = 16'hFFFF;
        age           = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_req) @(posedge clk);
                hold_off_req = 0;
            end
            if (age == 0)
            begin
                age = $urandom_range(50, 250);
                if ($urandom_range(0, 9) < 3)
                    stall_pattern = 16'hFFFF;
                else
                    stall_pattern = 16'($urandom) | 16'h0001;
            end
            age--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            m_tready      <= stall_pattern[0];
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin : idle_watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("soft_pot_gesture_classifier_core verification failed");
                $finish;
            end
        end
    end

    // every special case under the reset register values
    task automatic test_directed();
        send_item(OP_FETCH,  10'd0,    32'hFFFF_FFFF);  // fetch while idle
        send_item(OP_SAMPLE, 10'd5,    32'd100);        // equal to threshold, no touch
        send_item(OP_SAMPLE, 10'd0,    32'd110);        // below threshold, no touch
        send_item(OP_SAMPLE, 10'd1023, 32'hFFFF_FF00);  // button near time wrap
        send_item(OP_SAMPLE, 10'd900,  32'hFFFF_FF10);  // inside region
        send_item(OP_SAMPLE, 10'd873,  32'hFFFF_FF20);  // exactly region away
        send_item(OP_SAMPLE, 10'd500,  32'hFFFF_FF30);  // swipe
        send_item(OP_SAMPLE, 10'd800,  32'hFFFF_FF40);  // reversal, rub
        send_item(OP_FETCH,  10'd1023, 32'h0000_0010);  // unfinished, elapsed wraps
        send_item(OP_SAMPLE, 10'd300,  32'h0000_0800);  // hold turns rub to swipe
        send_item(OP_SAMPLE, 10'd900,  32'h0000_0900);  // reversal when held
        send_item(OP_SAMPLE, 10'd5,    32'h0000_0A00);  // threshold during touch
        send_item(OP_SAMPLE, 10'd4,    32'h0000_0B00);  // release
        send_item(OP_SAMPLE, 10'd3,    32'h0000_0C00);
        send_item(OP_FETCH,  10'd0,    32'h0000_0D00);  // clears finished touch
        send_item(OP_FETCH,  10'd0,    32'h0000_0E00);
        send_item(OP_SAMPLE, 10'd6,    32'd1000);       // just above threshold
        send_item(OP_SAMPLE, 10'd2,    32'd1500);       // release before hold
        send_item(OP_SAMPLE, 10'd0,    32'd3001);       // hold after release
        send_item(OP_SAMPLE, 10'd200,  32'd5000);       // new touch over finished one
        send_item(OP_FETCH,  10'd200,  32'd5100);
        send_item(OP_SAMPLE, 10'd0,    32'd5200);
        send_item(OP_FETCH,  10'd0,    32'h5555_AAAA);
        send_item(OP_FETCH,  10'h2AA,  32'hAAAA_5555);
        drain_reports();
    endtask

    // register extremes, each with a short run of touches
    task automatic test_register_extremes();
        int lt_set[7] = '{0, 1023, 0, 1023, 512, 1, 5};
        int mr_set[7] = '{0, 1023, 1023, 0, 1, 512, 150};
        int ht_set[7] = '{0, 65535, 1, 0, 65535, 300, 2000};
        for (int k = 0; k < 7; k++)
        begin
            set_thresholds(lt_set[k], mr_set[k], ht_set[k]);
            ms_clock = $urandom;
            run_gestures(50);
            drain_reports();
        end
    endtask

    // main random part over several register settings
    task automatic test_random_gestures();
        for (int k = 0; k < 8; k++)
        begin
            set_thresholds($urandom_range(0, 120), $urandom_range(0, 400),
                           $urandom_range(0, 3000));
            ms_clock = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : $urandom;
            no_gaps  = (k == 3);
            run_gestures(100);
            no_gaps  = 1'b0;
            drain_reports();
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_thresholds(5, 150, 2000);
        no_gaps      = 1'b1;
        hold_off_req = 300;
        run_gestures(80);
        no_gaps      = 1'b0;
        drain_reports();
    endtask

    // unstructured items with full-range fields
    task automatic test_noise();
        set_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 65535));
        repeat (200)
            send_noise_item();
        drain_reports();
    endtask

    // reset, then the tests in turn
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        thr_low      = LOW_THRESHOLD_RST;
        thr_move     = MOVE_REGION_RST;
        thr_hold     = HOLD_TIME_MS_RST;
        trk_kind     = KIND_NONE;
        trk_begin    = '0;
        trk_end      = '0;
        trk_start_ms = 32'd0;
        trk_held     = 1'b0;
        trk_done     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_gestures();
        test_backpressure();
        test_noise();
        if (errors == 0)
            $display("soft_pot_gesture_classifier_core verification clean");
        else
            $display("soft_pot_gesture_classifier_core verification failed");
        $finish;
    end

endmodule
